// ===== src/bclru_pkg.sv =====
`default_nettype none
package bclru_pkg;

    localparam int DEF_ENTRIES  = 32;
    localparam int DEF_TAG_BITS = 32;
    localparam int BN_W     = 32;
    localparam int SLOT_W   = 5;
    localparam int CNT_W    = 6;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam logic [CNT_W-1:0] THRESH_RESET = 6'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOSLOT  = 2'd3
    } status_t;

    // Operation broadcast from the controller to every cell.
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_HIT   = 4'd1,   // acquire hit on cell sel
        OP_SWEEP = 4'd2,   // drop the cell at this rank if free; older cells close the gap
        OP_INSTALL = 4'd3, // install at sel, age every other valid cell
        OP_REL   = 4'd4,
        OP_PIN   = 4'd5,
        OP_UNPIN = 4'd6
    } op_t;

    // Controller to cell bus.
    typedef struct packed {
        op_t               op;
        logic [7:0]        sel;       // addressed cell
        logic [7:0]        rank;      // rank for hit, sweep step
        logic              stop;      // sweep: count already below threshold
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== src/bclru_cell.sv =====
`default_nettype none
module bclru_cell #(
    parameter int TAG_BITS = 32,
    parameter int IDX      = 0,
    parameter int RANK_W   = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire bclru_pkg::cell_ctl_t  ctl,
    input  wire logic [TAG_BITS-1:0]   tag_in,
    input  wire logic                  drop_any,     // some cell drops this cycle
    // Chain: whether any lower-numbered cell is free, handed onward.
    input  wire logic                  free_in,      // some lower cell is free
    output logic                       free_out,
    output logic                       is_alloc,     // first free cell
    output logic                       match,
    output logic                       valid,
    output logic                       acquired,
    output logic                       drop_now,
    output logic [RANK_W-1:0]          rank
);
    import bclru_pkg::*;

    logic                valid_reg, acq_reg, pin_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [RANK_W-1:0]   rank_reg;

    assign valid    = valid_reg;
    assign acquired = acq_reg;
    assign rank     = rank_reg;
    assign match    = valid_reg && (tag_reg == tag_in);
    assign is_alloc = !valid_reg && !free_in;
    assign free_out = free_in || !valid_reg;
    assign drop_now = (ctl.op == OP_SWEEP) && !ctl.stop && valid_reg &&
                      (32'(rank_reg) == 32'(ctl.rank)) && !acq_reg && !pin_reg;

    // Control marks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            acq_reg   <= 1'b0;
            pin_reg   <= 1'b0;
        end else begin
            unique case (ctl.op)
                OP_HIT: begin
                    if (ctl.sel == 8'(IDX)) acq_reg <= 1'b1;
                end
                OP_SWEEP: begin
                    if (drop_now) valid_reg <= 1'b0;
                end
                OP_INSTALL: begin
                    if (ctl.sel == 8'(IDX)) begin
                        valid_reg <= 1'b1;
                        acq_reg   <= 1'b1;
                        pin_reg   <= 1'b0;
                    end
                end
                OP_REL:   if (ctl.sel == 8'(IDX)) acq_reg <= 1'b0;
                OP_PIN:   if (ctl.sel == 8'(IDX)) pin_reg <= 1'b1;
                OP_UNPIN: if (ctl.sel == 8'(IDX)) pin_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // Tag and rank payload.
    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            OP_HIT: begin
                if (ctl.sel == 8'(IDX)) rank_reg <= '0;
                else if (valid_reg && 32'(rank_reg) < 32'(ctl.rank))
                    rank_reg <= rank_reg + 1'b1;
            end
            OP_SWEEP: begin
                // The sweep runs from old to recent, so cells older than the
                // dropped rank have been visited already and simply move up.
                if (drop_any && valid_reg && 32'(rank_reg) > 32'(ctl.rank))
                    rank_reg <= rank_reg - 1'b1;
            end
            OP_INSTALL: begin
                if (ctl.sel == 8'(IDX)) begin
                    rank_reg <= '0;
                    tag_reg  <= tag_in;
                end else if (valid_reg) begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/block_cache_lru_policy.sv =====
// Block cache tag and LRU policy store with acquire/release and pinning.
// Input channel s_axis_*: tdata = cmd[1:0], block_number[33:2],
// slot_index[38:34]. Result channel m_axis_*: tdata = status[1:0], hit[2],
// slot[7:3], need_fill[8], evicted_count[14:9], cached_count[20:15].
// Configuration channel cfg_*: writes evict_threshold, only while idle.
// One item at a time. Release, pin, unpin and acquire hits present their
// result from the execute state that follows acceptance. An acquire miss
// goes on to the install state, after a sweep when the count has reached the
// threshold; the sweep visits one rank per cycle from least recent, starting
// at the valid count.
// Each entry is a cell holding its tag, marks and rank; the controller
// broadcasts one operation per cycle, and when the sweep drops an entry the
// older cells close the rank gap in the same cycle.
// The result sits in an output register; a new item is accepted once the
// previous result has been taken or is being taken. A stalled receiver holds
// the result and the block. Reset clears all entries and sets the threshold
// to 16.
`default_nettype none
module block_cache_lru_policy #(
    parameter int ENTRIES  = bclru_pkg::DEF_ENTRIES,
    parameter int TAG_BITS = bclru_pkg::DEF_TAG_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // cmd, block_number, slot_index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // status, hit, slot, need_fill,
                                             // evicted_count, cached_count
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data        // evict_threshold
);
    import bclru_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW     = $clog2(ENTRIES);
    localparam int NW     = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_INST  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [SLOT_W-1:0]   si_reg;
    logic [CNT_W-1:0]    thresh_reg;
    logic [NW-1:0]       count_reg, count_next;
    logic [NW-1:0]       sweep_reg, sweep_next;   // rank + 1 being visited
    logic [NW-1:0]       evict_reg, evict_next;
    logic                mvalid_reg;
    logic [23:0]         mdata_reg, mdata_next;
    logic                load;

    cell_ctl_t           ctl;
    logic [ENTRIES-1:0]  match, valid, acqd, drop_now, is_alloc;
    logic                drop_any;
    logic [ENTRIES:0]    free_c;
    logic [RANK_W-1:0]   ranks [ENTRIES];

    // Cell row.
    assign free_c[0] = 1'b0;
    assign drop_any  = |drop_now;
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        bclru_cell #(.TAG_BITS(TAG_BITS), .IDX(g), .RANK_W(RANK_W)) u_cell (
            .aclk, .aresetn, .ctl, .tag_in(tag_reg), .drop_any(drop_any),
            .free_in(free_c[g]), .free_out(free_c[g+1]), .is_alloc(is_alloc[g]),
            .match(match[g]), .valid(valid[g]), .acquired(acqd[g]),
            .drop_now(drop_now[g]), .rank(ranks[g])
        );
    end

    // Lookup results.
    logic              hit_any;
    logic [IW-1:0]     hit_idx, alloc_idx;
    logic              alloc_any;
    always_comb begin
        hit_any = 1'b0; hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (match[i]) begin hit_any = 1'b1; hit_idx = IW'(i); end
        alloc_any = |is_alloc;
        alloc_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
            if (is_alloc[i]) alloc_idx = IW'(i);
    end

    logic          si_ok;
    logic [IW-1:0] si_idx;
    assign si_idx = IW'(si_reg);
    assign si_ok  = (32'(si_reg) < ENTRIES) && valid[si_idx];

    function automatic logic [23:0] pack_res(
        input logic [1:0] st, input logic h, input logic [SLOT_W-1:0] sl,
        input logic f, input logic [CNT_W-1:0] ev, input logic [CNT_W-1:0] cc);
        pack_res = {3'b000, cc, ev, f, sl, h, st};
    endfunction

    assign load          = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && (!mvalid_reg || m_axis_tready);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    // Controller.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        sweep_next = sweep_reg;
        evict_next = evict_reg;
        mdata_next = mdata_reg;
        ctl.op     = OP_NONE;
        ctl.sel    = '0;
        ctl.rank   = '0;
        ctl.stop   = 1'b0;
        unique case (state_reg)
            S_IDLE: if (load) state_next = S_EXEC;
            S_EXEC: begin
                state_next = S_IDLE;
                evict_next = '0;
                if (cmd_reg == CMD_ACQUIRE) begin
                    if (hit_any) begin
                        mdata_next = pack_res(acqd[hit_idx] ? ST_BUSY : ST_OK, 1'b1,
                                              SLOT_W'(hit_idx), 1'b0, '0,
                                              CNT_W'(count_reg));
                        if (!acqd[hit_idx]) begin
                            ctl.op   = OP_HIT;
                            ctl.sel  = 8'(hit_idx);
                            ctl.rank = 8'(ranks[hit_idx]);
                        end
                    end else if (32'(count_reg) >= 32'(thresh_reg)) begin
                        state_next = S_SWEEP;
                        sweep_next = count_reg;
                    end else begin
                        state_next = S_INST;
                    end
                end else begin
                    mdata_next = pack_res(si_ok ? ST_OK : ST_NOSLOT, 1'b0, si_reg,
                                          1'b0, '0, CNT_W'(count_reg));
                    if (si_ok) begin
                        ctl.sel = 8'(si_reg);
                        unique case (cmd_t'(cmd_reg))
                            CMD_RELEASE: ctl.op = OP_REL;
                            CMD_PIN:     ctl.op = OP_PIN;
                            default:     ctl.op = OP_UNPIN;
                        endcase
                    end
                end
            end
            S_SWEEP: begin
                // Visit rank sweep_reg-1, least recent first.
                if (sweep_reg == '0) begin
                    state_next = S_INST;
                end else begin
                    ctl.op     = OP_SWEEP;
                    ctl.rank   = 8'(sweep_reg - 1'b1);
                    ctl.stop   = 32'(count_reg) < 32'(thresh_reg);
                    sweep_next = sweep_reg - 1'b1;
                    if (drop_any) begin
                        count_next = count_reg - 1'b1;
                        evict_next = evict_reg + 1'b1;
                    end
                end
            end
            S_INST: begin
                state_next = S_IDLE;
                if (alloc_any) begin
                    ctl.op     = OP_INSTALL;
                    ctl.sel    = 8'(alloc_idx);
                    count_next = count_reg + 1'b1;
                    mdata_next = pack_res(ST_OK, 1'b0, SLOT_W'(alloc_idx), 1'b1,
                                          CNT_W'(evict_reg), CNT_W'(count_reg + 1'b1));
                end else begin
                    mdata_next = pack_res(ST_FULL, 1'b0, '0, 1'b0,
                                          CNT_W'(evict_reg), CNT_W'(count_reg));
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            thresh_reg <= THRESH_RESET;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) thresh_reg <= cfg_data;
            if ((state_reg == S_EXEC && state_next == S_IDLE) || state_reg == S_INST)
                mvalid_reg <= 1'b1;
            else if (m_axis_tready)
                mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        sweep_reg <= sweep_next;
        evict_reg <= evict_next;
        mdata_reg <= mdata_next;
        if (load) begin
            cmd_reg <= s_axis_tdata[1:0];
            tag_reg <= TAG_BITS'(s_axis_tdata[33:2]);
            si_reg  <= s_axis_tdata[38:34];
        end
    end

    // Checks.
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) == 32'($countones(valid))) else $error("count mismatch");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_axis_tready) else $error("accept while busy");
endmodule
`default_nettype wire

// ===== tb/sv/tb_block_cache_lru_policy.sv =====
module tb_block_cache_lru_policy;
    timeunit 1ns;
    timeprecision 1ps;
    import bclru_pkg::*;

    localparam int NSLOT = DEF_ENTRIES;
    localparam int WDOG_LIMIT = 2000;

    // Fields from the highest bit down, so that status lands in the lowest bits.
    typedef struct packed {
        logic [CNT_W-1:0] cached;
        logic [CNT_W-1:0] evicted;
        logic             need_fill;
        logic [SLOT_W-1:0] slot;
        logic             hit;
        status_t          status;
    } lookup_res_t;

    // Mirror of the tag and recency store, predicting one result per beat.
    class cache_scoreboard;
        bit              valid[NSLOT];
        logic [BN_W-1:0] tag[NSLOT];
        bit              acq[NSLOT];
        bit              pinned[NSLOT];
        int              rank[NSLOT];
        int              count;
        int              thresh;
        lookup_res_t     pending[$];
        int              errors;
        int              checked;
        int              n_hit, n_miss, n_busy, n_full, n_noslot, n_swept;

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                valid[i] = 0; acq[i] = 0; pinned[i] = 0; rank[i] = 0; tag[i] = '0;
            end
            count = 0;
            thresh = int'(THRESH_RESET);
            errors = 0;
            checked = 0;
        endfunction

        // Drops free entries from least recent upward until below threshold.
        function int drop_unheld();
            int order[NSLOT];
            int n, dropped, nxt, s;
            n = count;
            dropped = 0;
            for (int i = 0; i < NSLOT; i++)
                if (valid[i] && rank[i] < n) order[rank[i]] = i;
            for (int r = n; r > 0; r--) begin
                s = order[r-1];
                if (count < thresh) break;
                if (!acq[s] && !pinned[s]) begin
                    valid[s] = 0;
                    count--;
                    dropped++;
                end
            end
            nxt = 0;
            for (int r = 0; r < n; r++) begin
                s = order[r];
                if (valid[s]) rank[s] = nxt++;
            end
            return dropped;
        endfunction

        function void note(cmd_t cmd, logic [BN_W-1:0] bn, logic [SLOT_W-1:0] si);
            lookup_res_t r;
            int found, fr, old;
            r = '0;
            r.status = ST_OK;
            if (cmd == CMD_ACQUIRE) begin
                found = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (found < 0 && valid[i] && tag[i] == bn) found = i;
                if (found >= 0) begin
                    r.hit = 1;
                    r.slot = SLOT_W'(found);
                    if (acq[found]) begin
                        r.status = ST_BUSY;
                        n_busy++;
                    end else begin
                        old = rank[found];
                        for (int i = 0; i < NSLOT; i++)
                            if (valid[i] && rank[i] < old) rank[i]++;
                        rank[found] = 0;
                        acq[found] = 1;
                        n_hit++;
                    end
                end else begin
                    if (count >= thresh) r.evicted = CNT_W'(drop_unheld());
                    if (r.evicted != 0) n_swept++;
                    fr = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (fr < 0 && !valid[i]) fr = i;
                    if (fr < 0) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        for (int i = 0; i < NSLOT; i++)
                            if (valid[i]) rank[i]++;
                        valid[fr] = 1; tag[fr] = bn; acq[fr] = 1;
                        pinned[fr] = 0; rank[fr] = 0;
                        count++;
                        r.slot = SLOT_W'(fr);
                        r.need_fill = 1;
                        n_miss++;
                    end
                end
            end else begin
                r.slot = si;
                if (!valid[si]) begin
                    r.status = ST_NOSLOT;
                    n_noslot++;
                end else if (cmd == CMD_RELEASE) acq[si] = 0;
                else if (cmd == CMD_PIN) pinned[si] = 1;
                else pinned[si] = 0;
            end
            r.cached = CNT_W'(count);
            pending.push_back(r);
        endfunction

        function void check(lookup_res_t got);
            lookup_res_t e;
            checked++;
            if (pending.size() == 0) begin
                $error("result beat with no expectation: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, got.status); errors++;
            end
            if (got.hit !== e.hit) begin
                $error("hit: expected %0d, got %0d", e.hit, got.hit); errors++;
            end
            if (got.slot !== e.slot) begin
                $error("slot: expected %0d, got %0d", e.slot, got.slot); errors++;
            end
            if (got.need_fill !== e.need_fill) begin
                $error("need_fill: expected %0d, got %0d", e.need_fill, got.need_fill);
                errors++;
            end
            if (got.evicted !== e.evicted) begin
                $error("evicted_count: expected %0d, got %0d", e.evicted, got.evicted);
                errors++;
            end
            if (got.cached !== e.cached) begin
                $error("cached_count: expected %0d, got %0d", e.cached, got.cached);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // cmd, block_number, slot_index
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;       // status, hit, slot, need_fill, evicted, cached
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [5:0]  cfg_data = '0;      // evict_threshold

    cache_scoreboard sb = new();
    int tx_idle = 0;
    int rx_idle = 0;
    int hold_left = 0;
    int quiet = 0;
    int n_items = 0;
    logic [BN_W-1:0] bn_pool[48];

    block_cache_lru_policy uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // Result side: check every beat taken.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check(lookup_res_t'(m_axis_tdata[20:0]));
    end

    // Receiver back-pressure, with one long hold-off.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_axis_tready = 0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rx_idle);
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WDOG_LIMIT) begin
            $display("tb_block_cache_lru_policy: FAIL");
            $finish;
        end
    end

    task automatic lookup(input cmd_t cmd, input logic [BN_W-1:0] bn,
                          input logic [SLOT_W-1:0] si);
        while ($urandom_range(99) < tx_idle) begin
            @(negedge aclk);
            s_axis_tvalid = 0;
        end
        @(negedge aclk);
        s_axis_tvalid = 1;
        s_axis_tdata = {1'b0, si, bn, cmd};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note(cmd, bn, si);
        n_items++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (NSLOT + 8) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [5:0] v);
        drain();
        @(negedge aclk);
        cfg_valid = 1;
        cfg_data = v;
        do @(posedge aclk); while (!cfg_ready);
        sb.thresh = int'(v);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    // One random item, mostly aimed at entries that are live.
    task automatic random_item();
        int k, si;
        cmd_t c;
        k = $urandom_range(99);
        si = $urandom_range(NSLOT - 1);
        if ($urandom_range(9) < 8) begin
            for (int t = 0; t < 8 && !sb.valid[si]; t++) si = $urandom_range(NSLOT - 1);
        end
        if (k < 45) begin
            if ($urandom_range(9) == 0) lookup(CMD_ACQUIRE, $urandom, SLOT_W'(si));
            else lookup(CMD_ACQUIRE, bn_pool[$urandom_range(47)], SLOT_W'(si));
        end else begin
            if (k < 75) c = CMD_RELEASE;
            else if (k < 88) c = CMD_PIN;
            else c = CMD_UNPIN;
            lookup(c, $urandom, SLOT_W'(si));
        end
    endtask

    initial begin
        logic [5:0] thr_list[6];
        thr_list = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd8, 6'd16};
        bn_pool[0] = '0;
        bn_pool[1] = '1;
        for (int i = 2; i < 48; i++) bn_pool[i] = $urandom;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: extremes, busy, repeated marks and unused slots.
        lookup(CMD_ACQUIRE, '0, '0);
        lookup(CMD_ACQUIRE, '1, '1);
        lookup(CMD_ACQUIRE, '0, '0);
        lookup(CMD_RELEASE, '1, 5'd0);
        lookup(CMD_ACQUIRE, '0, '0);
        lookup(CMD_RELEASE, '0, 5'd1);
        lookup(CMD_RELEASE, '0, 5'd1);
        lookup(CMD_PIN, '0, 5'd0);
        lookup(CMD_PIN, '0, 5'd0);
        lookup(CMD_UNPIN, '0, 5'd1);
        lookup(CMD_UNPIN, '1, 5'd1);
        lookup(CMD_RELEASE, '0, 5'd31);
        lookup(CMD_PIN, '1, 5'd31);
        lookup(CMD_UNPIN, '0, 5'd30);

        // Fill every entry so that the last misses of this loop report full.
        set_threshold(6'd63);
        for (int i = 0; i < 32; i++) lookup(CMD_ACQUIRE, $urandom, '0);
        lookup(CMD_PIN, '0, 5'd3);
        lookup(CMD_RELEASE, '0, 5'd3);

        // Random phases over several thresholds and idling patterns.
        for (int p = 0; p < 6; p++) begin
            set_threshold(thr_list[p]);
            if (p < 2) begin
                tx_idle = 20; rx_idle = 74;
            end else if (p < 4) begin
                tx_idle = 74; rx_idle = 20;
            end else begin
                tx_idle = 0; rx_idle = 0;
            end
            for (int i = 0; i < 210; i++) begin
                if (p == 0 && i == 100) hold_left = 300;
                if (i % 70 == 40) tx_idle = 0;
                if (i % 70 == 60) tx_idle = (p < 2) ? 20 : (p < 4) ? 74 : 0;
                random_item();
            end
        end

        drain();
        $display("Sent %0d lookups over six thresholds; %0d hits, %0d misses, %0d busy,",
                 n_items, sb.n_hit, sb.n_miss, sb.n_busy);
        $display("%0d full, %0d bad slots, %0d sweeps that dropped entries, %0d checked.",
                 sb.n_full, sb.n_noslot, sb.n_swept, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_block_cache_lru_policy: PASS");
        end else begin
            $display("tb_block_cache_lru_policy: FAIL");
        end
        $finish;
    end
endmodule
